FILE: design/kfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator package
// Shared types, codes and defaults for the keyframe interpolator.
// ----------------------------------------------------------------------------
package kfi_pkg;

    localparam int MAX_KEYS_DEF = 256;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] INTERP_LINEAR  = 2'd0;
    localparam logic [1:0] INTERP_HERMITE = 2'd1;
    localparam logic [1:0] INTERP_STEP    = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key_time;
        logic signed [31:0] key_value;
        logic signed [31:0] key_backward;
        logic signed [31:0] key_forward;
        logic signed [31:0] query_time;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] out_value;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT,
        S_CMP,
        S_FRAC,
        S_DIV,
        S_RD1W,
        S_RD1,
        S_RD2W,
        S_RD2,
        S_MUL,
        S_FIN
    } state_t;

endpackage

FILE: design/kfi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/keyframe_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator
// Key table with linear, cubic Hermite or step sampling, one item at a time.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on result with done high for exactly one cycle, and the receiver
// cannot hold it off. Clear and append report done in the cycle after they
// are taken. A query walks the key table from the cached index, visiting each
// key through S_WAIT and S_CMP (the key RAM has one registered read port),
// then runs a restoring divide for the 16-bit fraction when the pair differs
// in time, fetches both keys through S_RD1W (skipped after the divide),
// S_RD1, S_RD2W and S_RD2, and uses one shared multiplier, once for linear or
// step and for x squared, x cubed and four weighted terms for Hermite, before
// S_FIN truncates and saturates. A query at or beyond the first or last key
// time is clamped to that key and skips the walk.
module keyframe_interpolator #(
    parameter int MAX_KEYS = kfi_pkg::MAX_KEYS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  kfi_pkg::in_item_t item,
    output logic              done,
    output kfi_pkg::out_item_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata
);
    import kfi_pkg::*;

    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    state_t state_reg, state_next;

    logic [IW-1:0]      rd_addr_reg, rd_addr_next;
    logic               dir_down_reg, dir_down_next;
    logic               first_reg, first_next;
    logic signed [31:0] q_reg, q_next;
    logic signed [31:0] t1_reg, t1_next, t2_reg, t2_next, prev_t_reg, prev_t_next;
    logic [IW-1:0]      k1_reg, k1_next, k2_reg, k2_next;
    logic [33:0]        rem_reg, rem_next, den_reg, den_next;
    logic [15:0]        x_reg, x_next, x2_reg, x2_next, x3_reg, x3_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [2:0]         step_reg, step_next;
    logic signed [31:0] v1_reg, v1_next, b1_reg, b1_next, v2_reg, v2_next, f2_reg, f2_next;
    logic signed [53:0] acc_reg, acc_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      cached_reg, cached_next;
    logic signed [31:0] first_time_reg, first_time_next, last_time_reg, last_time_next;
    logic [1:0]         interp_reg;
    logic               done_reg, done_next;
    out_item_t          result_reg, result_next;

    logic               accept;
    logic               append_ok;
    logic [IW-1:0]      last_idx;
    logic [127:0]       rdata;
    logic signed [31:0] rd_time;
    logic               cmp_lt, cmp_gt, cmp_eq, walk_more;
    logic signed [32:0] den_w, num_w;
    logic               frac_div;
    logic               hermite, stepmode, mul_last;
    logic [33:0]        rem_sh;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] prod;
    logic signed [19:0] h00, h01, h10, h11;
    logic signed [37:0] acc_shr;
    logic signed [31:0] fin_value;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign last_idx  = IW'(count_reg - CW'(1));
    assign append_ok = (count_reg < CW'(MAX_KEYS))
                       && ((count_reg == '0) || (item.key_time >= last_time_reg));

    kfi_ram #(
        .WIDTH (128),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (accept && (item.mode == CMD_APPEND) && append_ok),
        .waddr (count_reg[IW-1:0]),
        .wdata ({item.key_time, item.key_value, item.key_backward, item.key_forward}),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    assign rd_time = rdata[127:96];
    assign cmp_lt  = rd_time < q_reg;
    assign cmp_gt  = rd_time > q_reg;
    assign cmp_eq  = !cmp_lt && !cmp_gt;

    always_comb
    begin
        if (first_reg)
        begin
            walk_more = !cmp_eq;
        end
        else if (dir_down_reg)
        begin
            walk_more = (rd_addr_reg != '0) && cmp_gt;
        end
        else
        begin
            walk_more = (rd_addr_reg < last_idx) && cmp_lt;
        end
    end

    assign den_w    = 33'(t2_reg) - 33'(t1_reg);
    assign num_w    = 33'(q_reg) - 33'(t1_reg);
    assign frac_div = (k1_reg != k2_reg) && (den_w > 0) && (num_w > 0);
    assign rem_sh   = {rem_reg[32:0], 1'b0};

    assign hermite  = (interp_reg == INTERP_HERMITE);
    assign stepmode = (interp_reg == INTERP_STEP);
    assign mul_last = hermite ? (step_reg == 3'd5) : 1'b1;

    // Hermite basis weights in Q16, formed from the registered powers of x.
    assign h00 = 20'(20'sd65536 + 20'({4'b0, x3_reg}) * 2 - 20'({4'b0, x2_reg}) * 3);
    assign h01 = 20'(20'({4'b0, x2_reg}) * 3 - 20'({4'b0, x3_reg}) * 2);
    assign h10 = 20'(20'({4'b0, x3_reg}) - 20'({4'b0, x2_reg}) * 2 + 20'({4'b0, x_reg}));
    assign h11 = 20'({4'b0, x3_reg}) - 20'({4'b0, x2_reg});

    always_comb
    begin
        mul_a = 34'(v2_reg) - 34'(v1_reg);
        mul_b = 18'({2'b0, x_reg});
        if (hermite)
        begin
            case (step_reg)
                3'd0:    begin mul_a = 34'({18'b0, x_reg});  mul_b = 18'({2'b0, x_reg}); end
                3'd1:    begin mul_a = 34'({18'b0, x2_reg}); mul_b = 18'({2'b0, x_reg}); end
                3'd2:    begin mul_a = 34'(v1_reg); mul_b = h00[17:0]; end
                3'd3:    begin mul_a = 34'(v2_reg); mul_b = h01[17:0]; end
                3'd4:    begin mul_a = 34'(b1_reg); mul_b = h10[17:0]; end
                default: begin mul_a = 34'(f2_reg); mul_b = h11[17:0]; end
            endcase
        end
    end

    assign prod = mul_a * mul_b;

    assign acc_shr = acc_reg[53:16];
    always_comb
    begin
        if (stepmode)
        begin
            fin_value = (x_reg < 16'd32768) ? v1_reg : v2_reg;
        end
        else if (acc_shr > 38'sd2147483647)
        begin
            fin_value = 32'sh7FFFFFFF;
        end
        else if (acc_shr < -38'sd2147483648)
        begin
            fin_value = 32'sh80000000;
        end
        else
        begin
            fin_value = acc_shr[31:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.mode == CMD_QUERY) && (count_reg != '0))
                begin
                    if ((item.query_time <= first_time_reg)
                        || (item.query_time >= last_time_reg))
                    begin
                        state_next = S_FRAC;
                    end
                    else
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT: state_next = S_CMP;
            S_CMP:  state_next = walk_more ? S_WAIT : S_FRAC;
            S_FRAC: state_next = frac_div ? S_DIV : S_RD1W;
            S_DIV:  state_next = (cnt_reg == 4'd15) ? S_RD1 : S_DIV;
            S_RD1W: state_next = S_RD1;
            S_RD1:  state_next = S_RD2W;
            S_RD2W: state_next = S_RD2;
            S_RD2:  state_next = S_MUL;
            S_MUL:  state_next = mul_last ? S_FIN : S_MUL;
            S_FIN:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and result.
    always_comb
    begin
        rd_addr_next    = rd_addr_reg;
        dir_down_next   = dir_down_reg;
        first_next      = first_reg;
        q_next          = q_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        prev_t_next     = prev_t_reg;
        k1_next         = k1_reg;
        k2_next         = k2_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        x_next          = x_reg;
        x2_next         = x2_reg;
        x3_next         = x3_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        v1_next         = v1_reg;
        b1_next         = b1_reg;
        v2_next         = v2_reg;
        f2_next         = f2_reg;
        acc_next        = acc_reg;
        count_next      = count_reg;
        cached_next     = cached_reg;
        first_time_next = first_time_reg;
        last_time_next  = last_time_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    q_next = item.query_time;
                    result_next.out_value = '0;
                    result_next.ok        = 1'b0;
                    case (item.mode)
                        CMD_CLEAR:
                        begin
                            count_next     = '0;
                            result_next.ok = 1'b1;
                            done_next      = 1'b1;
                        end
                        CMD_APPEND:
                        begin
                            if (append_ok)
                            begin
                                if (count_reg == '0)
                                begin
                                    first_time_next = item.key_time;
                                end
                                last_time_next = item.key_time;
                                count_next     = count_reg + CW'(1);
                                result_next.ok = 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else if (item.query_time <= first_time_reg)
                            begin
                                k1_next = '0;
                                k2_next = '0;
                                t1_next = first_time_reg;
                                t2_next = first_time_reg;
                            end
                            else if (item.query_time >= last_time_reg)
                            begin
                                k1_next = last_idx;
                                k2_next = last_idx;
                                t1_next = last_time_reg;
                                t2_next = last_time_reg;
                            end
                            else
                            begin
                                // A cached index past the table end restarts at key zero.
                                rd_addr_next = (cached_reg <= last_idx) ? cached_reg : '0;
                                first_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                first_next  = 1'b0;
                prev_t_next = rd_time;
                if (first_reg)
                begin
                    dir_down_next = cmp_gt;
                    if (cmp_lt)
                    begin
                        rd_addr_next = rd_addr_reg + IW'(1);
                    end
                    else if (cmp_gt)
                    begin
                        rd_addr_next = rd_addr_reg - IW'(1);
                    end
                    else
                    begin
                        k1_next = rd_addr_reg;
                        k2_next = rd_addr_reg;
                        t1_next = rd_time;
                        t2_next = rd_time;
                    end
                end
                else if (walk_more)
                begin
                    rd_addr_next = dir_down_reg ? rd_addr_reg - IW'(1) : rd_addr_reg + IW'(1);
                end
                else if (dir_down_reg)
                begin
                    k1_next = rd_addr_reg;
                    t1_next = rd_time;
                    k2_next = cmp_eq ? rd_addr_reg : rd_addr_reg + IW'(1);
                    t2_next = cmp_eq ? rd_time : prev_t_reg;
                end
                else
                begin
                    k2_next = rd_addr_reg;
                    t2_next = rd_time;
                    k1_next = cmp_eq ? rd_addr_reg : rd_addr_reg - IW'(1);
                    t1_next = cmp_eq ? rd_time : prev_t_reg;
                end
            end
            S_FRAC:
            begin
                cached_next  = k1_reg;
                rd_addr_next = k1_reg;
                x_next       = '0;
                cnt_next     = '0;
                rem_next     = {1'b0, num_w};
                den_next     = {1'b0, den_w};
            end
            S_DIV:
            begin
                // One quotient bit per cycle; the numerator is below the divisor.
                cnt_next = cnt_reg + 4'd1;
                if (rem_sh >= den_reg)
                begin
                    rem_next = rem_sh - den_reg;
                    x_next   = {x_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    x_next   = {x_reg[14:0], 1'b0};
                end
            end
            S_RD1:
            begin
                v1_next      = rdata[95:64];
                b1_next      = rdata[63:32];
                rd_addr_next = k2_reg;
            end
            S_RD2:
            begin
                v2_next   = rdata[95:64];
                f2_next   = rdata[31:0];
                step_next = '0;
            end
            S_MUL:
            begin
                step_next = step_reg + 3'd1;
                if (hermite)
                begin
                    case (step_reg)
                        3'd0:    x2_next  = prod[31:16];
                        3'd1:    x3_next  = prod[31:16];
                        3'd2:    acc_next = 54'(prod);
                        default: acc_next = acc_reg + 54'(prod);
                    endcase
                end
                else
                begin
                    acc_next = {{6{v1_reg[31]}}, v1_reg, 16'b0} + 54'(prod);
                end
            end
            S_FIN:
            begin
                result_next.ok        = 1'b1;
                result_next.out_value = fin_value;
                done_next             = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            cached_reg     <= '0;
            interp_reg     <= INTERP_LINEAR;
            done_reg       <= 1'b0;
            first_reg      <= 1'b0;
            dir_down_reg   <= 1'b0;
            cnt_reg        <= '0;
            step_reg       <= '0;
            rd_addr_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cached_reg     <= cached_next;
            done_reg       <= done_next;
            first_reg      <= first_next;
            dir_down_reg   <= dir_down_next;
            cnt_reg        <= cnt_next;
            step_reg       <= step_next;
            rd_addr_reg    <= rd_addr_next;
            if (cfg_we)
            begin
                interp_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        t1_reg         <= t1_next;
        t2_reg         <= t2_next;
        prev_t_reg     <= prev_t_next;
        k1_reg         <= k1_next;
        k2_reg         <= k2_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        x_reg          <= x_next;
        x2_reg         <= x2_next;
        x3_reg         <= x3_next;
        v1_reg         <= v1_next;
        b1_reg         <= b1_next;
        v2_reg         <= v2_next;
        f2_reg         <= f2_next;
        acc_reg        <= acc_next;
        first_time_reg <= first_time_next;
        last_time_reg  <= last_time_next;
        result_reg     <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe interpolator testbench
// Builds key tables, samples them under every blend mode and compares each
// result with a behavioral copy of the key table and its sampler.
// ----------------------------------------------------------------------------
module tb_top;
    import kfi_pkg::*;

    localparam int  DEPTH     = MAX_KEYS_DEF;
    localparam int  WD_LIMIT  = 4000;
    localparam int  ITEM_GOAL = 900;
    localparam longint T_MIN  = -64'sd2147483648;
    localparam longint T_MAX  = 64'sd2147483647;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    in_item_t   item = '0;
    logic       done;
    out_item_t  result;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_wdata = INTERP_LINEAR;

    always #6 clk = ~clk;

    keyframe_interpolator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Behavioral copy of the key table.
    longint     key_t [DEPTH];
    longint     key_v [DEPTH];
    longint     key_b [DEPTH];
    longint     key_f [DEPTH];
    int         key_count = 0;
    int         cache_idx = 0;
    logic [1:0] blend_mode = INTERP_LINEAR;

    in_item_t   pending_q [$];
    out_item_t  expected_q [$];
    longint     phase_times [$];
    int         errors = 0;
    int         items_sent = 0;
    int         items_taken = 0;
    int         queries_sent = 0;
    int         results_seen = 0;
    int         quiet_cycles = 0;
    bit         taken = 1'b0;
    bit         calm = 1'b0;

    function automatic longint sat32(longint x);
        if (x > T_MAX) return T_MAX;
        if (x < T_MIN) return T_MIN;
        return x;
    endfunction

    function automatic longint sample_at(longint q);
        int     last, k1, k2, i;
        longint x, v1, v2, r, num, den, x2, x3, h00, h01, h10, h11;
        last = key_count - 1;
        x = 0;
        if (q <= key_t[0]) begin
            k1 = 0;
            k2 = 0;
        end else if (q >= key_t[last]) begin
            k1 = last;
            k2 = last;
        end else begin
            i = (cache_idx <= last) ? cache_idx : 0;
            if (key_t[i] < q) begin
                do i++; while (i < last && key_t[i] < q);
                k1 = (key_t[i] == q) ? i : i - 1;
                k2 = i;
            end else if (key_t[i] > q) begin
                do i--; while (i > 0 && key_t[i] > q);
                k1 = i;
                k2 = (key_t[i] == q) ? i : i + 1;
            end else begin
                k1 = i;
                k2 = i;
            end
        end
        if (k1 != k2) begin
            den = key_t[k2] - key_t[k1];
            num = q - key_t[k1];
            if (den > 0 && num > 0) begin
                x = (num <<< 16) / den;
                if (x > 65535) x = 65535;
            end
        end
        cache_idx = k1;
        v1 = key_v[k1];
        v2 = key_v[k2];
        if (blend_mode == INTERP_HERMITE) begin
            x2  = (x * x) >>> 16;
            x3  = (x2 * x) >>> 16;
            h00 = 2 * x3 - 3 * x2 + 65536;
            h01 = -2 * x3 + 3 * x2;
            h10 = x3 - 2 * x2 + x;
            h11 = x3 - x2;
            r = (v1 * h00 + v2 * h01 + key_b[k1] * h10 + key_f[k2] * h11) >>> 16;
        end else if (blend_mode == INTERP_STEP) begin
            r = (x < 32768) ? v1 : v2;
        end else begin
            r = v1 + (((v2 - v1) * x) >>> 16);
        end
        return sat32(r);
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t o;
        longint    t;
        o = '0;
        t = longint'($signed(it.key_time));
        case (it.mode)
            CMD_CLEAR: begin
                key_count = 0;
                o.ok = 1'b1;
            end
            CMD_APPEND: begin
                if (key_count < DEPTH && (key_count == 0 || t >= key_t[key_count - 1])) begin
                    key_t[key_count] = t;
                    key_v[key_count] = longint'($signed(it.key_value));
                    key_b[key_count] = longint'($signed(it.key_backward));
                    key_f[key_count] = longint'($signed(it.key_forward));
                    key_count++;
                    o.ok = 1'b1;
                end
            end
            CMD_QUERY: begin
                if (key_count > 0) begin
                    o.out_value = 32'(sample_at(longint'($signed(it.query_time))));
                    o.ok = 1'b1;
                end
            end
            default: o.ok = 1'b0;
        endcase
        return o;
    endfunction

    // Monitor: configuration writes, accepted items and results.
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n) begin
            if (done) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result ok=%0b value=%h", $time,
                             result.ok, result.out_value);
                end else begin
                    want = expected_q.pop_front();
                    if (result.ok !== want.ok) begin
                        errors++;
                        $display("%0t: ok mismatch expected %0b actual %0b", $time,
                                 want.ok, result.ok);
                    end
                    if (result.out_value !== want.out_value) begin
                        errors++;
                        $display("%0t: value mismatch expected %h actual %h", $time,
                                 want.out_value, result.out_value);
                    end
                end
            end
            if (cfg_we)
                blend_mode = cfg_wdata;
            if (start && !busy) begin
                expected_q.push_back(predict_result(item));
                items_taken++;
                taken = 1'b1;
            end
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Driver: presents the next pending item, idling now and then.
    always @(negedge clk) begin
        if (rst_n && (taken || !start)) begin
            taken = 1'b0;
            if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
                item  <= pending_q.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic longint rand32();
        return longint'($signed($urandom()));
    endfunction

    task automatic push_item(logic [1:0] m, longint t, longint v, longint b, longint f,
                             longint q);
        in_item_t it;
        it.mode         = m;
        it.key_time     = 32'(t);
        it.key_value    = 32'(v);
        it.key_backward = 32'(b);
        it.key_forward  = 32'(f);
        it.query_time   = 32'(q);
        pending_q.push_back(it);
        items_sent++;
        if (m == CMD_QUERY) queries_sent++;
    endtask

    task automatic push_append(longint t, longint v, longint b, longint f);
        push_item(CMD_APPEND, t, v, b, f, rand32());
    endtask

    task automatic push_query(longint q);
        push_item(CMD_QUERY, rand32(), rand32(), rand32(), rand32(), q);
    endtask

    // Waits until every item has been accepted and its result has come back.
    task automatic drain();
        while (items_taken != items_sent || expected_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_blend(logic [1:0] m);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic longint rand_span(longint lo, longint hi);
        return lo + longint'({$urandom(), $urandom()} % 64'(hi - lo + 1));
    endfunction

    function automatic longint rand_payload();
        case ($urandom_range(3))
            0: return rand32();
            1: return longint'($urandom_range(0, 20)) * 65536 - 10 * 65536;
            2: return ($urandom_range(1)) ? T_MAX : T_MIN;
            default: return longint'($signed($urandom_range(0, 32'hffff))) - 32768;
        endcase
    endfunction

    // One table: clear, sorted keys with some noise, then queries.
    task automatic run_table(int nkeys, int nqueries, bit wide);
        longint t, step, lo, hi;
        phase_times.delete();
        push_item(CMD_CLEAR, rand32(), rand32(), rand32(), rand32(), rand32());
        t = wide ? rand_span(T_MIN, 0) : rand_span(T_MIN, T_MAX - 64'sd1000000);
        for (int k = 0; k < nkeys; k++) begin
            if ($urandom_range(99) < 8 && phase_times.size() > 0 && t > T_MIN) begin
                push_append(rand_span(T_MIN, t - 1), rand_payload(), rand_payload(),
                            rand_payload());
            end else if ($urandom_range(99) < 3) begin
                push_item(CMD_NONE, rand32(), rand32(), rand32(), rand32(), rand32());
            end
            push_append(t, rand_payload(), rand_payload(), rand_payload());
            phase_times.push_back(t);
            case ($urandom_range(9))
                0:       step = 0;
                1, 2:    step = $urandom_range(1, 3);
                3:       step = longint'($urandom());
                default: step = $urandom_range(1, 5 * 65536);
            endcase
            t = (t + step > T_MAX) ? T_MAX : t + step;
        end
        lo = phase_times[0];
        hi = phase_times[phase_times.size() - 1];
        for (int k = 0; k < nqueries; k++) begin
            case ($urandom_range(9))
                0:       push_query(rand32());
                1:       push_query(phase_times[$urandom_range(phase_times.size() - 1)]);
                2:       push_query(($urandom_range(1)) ? T_MIN : T_MAX);
                default: push_query(rand_span(lo, hi));
            endcase
        end
    endtask

    initial begin
        int blend;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, ignored selector, extremes, equal and
        // out-of-order times, then the same shape under every blend mode.
        for (int m = 0; m < 4; m++) begin
            set_blend(2'(m));
            push_query(0);
            push_item(CMD_NONE, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX);
            push_append(T_MIN, T_MAX, T_MIN, T_MAX);
            push_append(0, T_MIN, T_MAX, T_MIN);
            push_append(0, 65536, 0, 0);
            push_append(-5, 1, 1, 1);
            push_append(T_MAX, T_MAX, T_MAX, T_MIN);
            push_query(T_MIN);
            push_query(T_MAX);
            push_query(0);
            push_query(1);
            push_query(-100);
            push_query(64'sd1073741824);
            push_query(-64'sd1073741824);
            push_item(CMD_CLEAR, 0, 0, 0, 0, 0);
            push_query(5);
        end

        // A full table: appends past the limit are dropped.
        set_blend(INTERP_HERMITE);
        run_table(DEPTH + 3, 30, 1'b0);

        blend = 0;
        while (items_sent < ITEM_GOAL) begin
            set_blend(2'(blend));
            blend = (blend + 1) % 4;
            calm = (items_sent > 500 && items_sent < 700);
            run_table($urandom_range(1, 12), $urandom_range(4, 20), $urandom_range(1));
        end
        drain();
        calm = 1'b0;
        repeat (50) @(posedge clk);

        $display("Sent %0d items (%0d queries) over all blend modes; %0d results checked.",
                 items_sent, queries_sent, results_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/kfi_pkg.sv
design/kfi_ram.sv
design/keyframe_interpolator.sv
tb/tb_top.sv
